### src/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the stable priority task queue
// Entry layout, pointer widths, status codes and circular index helpers.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned IDX_W       = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned HANDLE_W = 64;
  localparam int unsigned PRIO_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 5;

  localparam int unsigned IN_DATA_W  = 96;  // handle + priority
  localparam int unsigned OUT_DATA_W = 72;  // handle + status + occupancy, byte padded

  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [PRIO_W-1:0]   prio;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  function automatic idx_t idx_next(idx_t i);
    idx_t r;
    if (i == idx_t'(QUEUE_DEPTH - 1)) r = '0;
    else r = i + idx_t'(1);
    return r;
  endfunction

  function automatic idx_t idx_prev(idx_t i);
    idx_t r;
    if (i == '0) r = idx_t'(QUEUE_DEPTH - 1);
    else r = i - idx_t'(1);
    return r;
  endfunction

  function automatic idx_t idx_add(idx_t i, cnt_t n);
    logic [CNT_W:0] s;
    s = {{(CNT_W + 1 - IDX_W){1'b0}}, i} + {1'b0, n};
    if (s >= (CNT_W + 1)'(QUEUE_DEPTH)) s = s - (CNT_W + 1)'(QUEUE_DEPTH);
    return s[IDX_W-1:0];
  endfunction

endpackage

### src/spq_ram.sv
// ----------------------------------------------------------------------------
// spq_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module spq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### src/stable_priority_task_queue.sv
// Pop: the head entry is read, unlinked, and then the result is sent.
// Insert: the k stored entries with a greater priority are shifted one place,
//   walked from the tail one per cycle through the entry RAM's single read and
//   write port; full insert and empty pop answer without a RAM access.
// One item at a time: a new item is taken only once the last result is registered.
// Reset clears head pointer, count and handshake state; the RAM is not cleared.
// ----------------------------------------------------------------------------
// stable_priority_task_queue: sorted task list with first-in first-out ties
// Circular list in one RAM; insert shifts larger entries toward the tail.
// ----------------------------------------------------------------------------
module stable_priority_task_queue (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [spq_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // task_handle, task_priority
  input  logic                           s_axis_tuser,   // command
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [spq_pkg::OUT_DATA_W-1:0] m_axis_tdata    // popped_handle, status, occupancy, pad
);
  import spq_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_POP   = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_PLACE = 5'b01000,
    ST_RESP  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  idx_t   head_q, head_d;
  cnt_t   count_q, count_d;
  cnt_t   remain_q, remain_d;
  idx_t   pos_q, pos_d;
  entry_t req_q, req_d;
  logic   [HANDLE_W-1:0] res_handle_q, res_handle_d;
  logic   [STATUS_W-1:0] res_status_q, res_status_d;
  logic   out_valid_q, out_valid_d;
  logic   [OUT_DATA_W-1:0] out_data_q, out_data_d;

  logic   ram_we;
  idx_t   ram_waddr, ram_raddr;
  entry_t ram_wdata, ram_rdata;
  logic   in_fire, out_free;
  idx_t   tail, cur;
  entry_t in_entry;

  spq_ram #(
    .Width(ENTRY_W),
    .Depth(QUEUE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign in_entry.handle = s_axis_tdata[HANDLE_W-1:0];
  assign in_entry.prio   = s_axis_tdata[HANDLE_W +: PRIO_W];
  assign tail = idx_add(head_q, count_q);
  assign cur  = idx_prev(pos_q);

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    count_d      = count_q;
    remain_d     = remain_q;
    pos_d        = pos_q;
    req_d        = req_q;
    res_handle_d = res_handle_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_data_d   = out_data_q;
    ram_we       = 1'b0;
    ram_waddr    = pos_q;
    ram_wdata    = req_q;
    ram_raddr    = head_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          req_d        = in_entry;
          res_handle_d = '0;
          res_status_d = STATUS_DONE;
          pos_d        = tail;
          remain_d     = count_q;
          if (s_axis_tuser == CMD_POP) begin
            if (count_q == '0) begin
              res_status_d = STATUS_EMPTY;
              state_d      = ST_RESP;
            end else begin
              state_d = ST_POP;
            end
          end else if (count_q == cnt_t'(QUEUE_DEPTH)) begin
            res_status_d = STATUS_FULL;
            state_d      = ST_RESP;
          end else if (count_q == '0) begin
            state_d = ST_PLACE;
          end else begin
            ram_raddr = idx_prev(tail);
            state_d   = ST_SCAN;
          end
        end
      end
      ST_POP: begin
        res_handle_d = ram_rdata.handle;
        head_d       = idx_next(head_q);
        count_d      = count_q - cnt_t'(1);
        state_d      = ST_RESP;
      end
      ST_SCAN: begin
        ram_we    = 1'b1;
        ram_raddr = idx_prev(cur);
        if (req_q.prio < ram_rdata.prio) begin
          ram_wdata = ram_rdata;
          pos_d     = cur;
          remain_d  = remain_q - cnt_t'(1);
          if (remain_q == cnt_t'(1)) begin
            state_d = ST_PLACE;
          end
        end else begin
          count_d = count_q + cnt_t'(1);
          state_d = ST_RESP;
        end
      end
      ST_PLACE: begin
        ram_we  = 1'b1;
        count_d = count_q + cnt_t'(1);
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {1'b0, OCC_W'(count_q), res_status_q, res_handle_q};
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    remain_q     <= remain_d;
    pos_q        <= pos_d;
    req_q        <= req_d;
    res_handle_q <= res_handle_d;
    res_status_q <= res_status_d;
    out_data_q   <= out_data_d;
  end

endmodule

### src/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker: port-level checks of the stable priority task queue
// Watches both stream sides and is bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [spq_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import spq_pkg::*;

  logic [STATUS_W-1:0] st;
  assign st = m_axis_tdata[HANDLE_W +: STATUS_W];

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while an item is in flight");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (st == STATUS_DONE || st == STATUS_EMPTY || st == STATUS_FULL))
    else $error("undefined status code");

  a_zero_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && st != STATUS_DONE) |-> (m_axis_tdata[HANDLE_W-1:0] == '0))
    else $error("handle set on a failed item");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("output beat changed while stalled");

endmodule

bind stable_priority_task_queue spq_checker u_spq_checker (.*);
